// ----- hdl/lhr_pkg.sv -----
// Shared types and constants of the line history ring.
// No dependencies; imported by every module of the block.
package lhr_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;
  localparam int LINE_LENGTH_DEF   = 64;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CHAR_W            = 8;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 16;
  localparam int TUSER_W           = 2;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_PREV   = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_CURSOR = 2'd3
  } in_kind_t;

  typedef enum logic [1:0] {
    RK_STATUS = 2'd0,
    RK_CHAR   = 2'd1,
    RK_NONE   = 2'd2
  } result_kind_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_DUP    = 2'd2
  } add_status_t;

  // request classes produced by the front end
  typedef enum logic [2:0] {
    OP_CHAR,
    OP_END,
    OP_PREV,
    OP_NEXT,
    OP_CURSOR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CMP,
    B_DUP,
    B_COPY,
    B_TERM,
    B_ERD,
    B_EMIT,
    B_SEND
  } back_state_t;

endpackage

// ----- hdl/lhr_front.sv -----
// Front end: accepts input requests, classifies them and queues them.
// Depends on lhr_pkg.
module lhr_front import lhr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] character
  input  logic [TUSER_W-1:0]    in_tuser,   // [1:0] kind
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_ready
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  cmd_t            cmd_in;
  logic            push, pop;

  always_comb begin
    cmd_in.ch = in_tdata[CHAR_W-1:0];
    case (in_kind_t'(in_tuser))
      KIND_CHAR:   cmd_in.op = (in_tdata[CHAR_W-1:0] == '0) ? OP_END : OP_CHAR;
      KIND_PREV:   cmd_in.op = OP_PREV;
      KIND_NEXT:   cmd_in.op = OP_NEXT;
      KIND_CURSOR: cmd_in.op = OP_CURSOR;
      default:     cmd_in.op = OP_CURSOR;
    endcase
  end

  assign in_tready = (fill_r != FW'(QUEUE_DEPTH));
  assign q_valid   = (fill_r != '0);
  assign q_cmd     = slot_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + FW'(push) - FW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- hdl/lhr_back.sv -----
// Back end: staging buffer, history store, browse cursor and result register.
// Depends on lhr_pkg; fed by lhr_front.
module lhr_back import lhr_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LINE_LENGTH   = LINE_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  cmd_t                   q_cmd,
  output logic                   q_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0]     out_tuser,
  output logic                   out_tlast
);

  localparam int SW     = $clog2(HISTORY_DEPTH);
  localparam int CNTW   = $clog2(HISTORY_DEPTH + 1);
  localparam int CNTW1  = CNTW + 1;
  localparam int LW     = $clog2(LINE_LENGTH);
  localparam int MDEPTH = HISTORY_DEPTH * LINE_LENGTH;
  localparam int AW     = $clog2(MDEPTH);
  localparam int TW     = $clog2(3 * HISTORY_DEPTH + 1);
  localparam int PADW   = OUT_TDATA_W - CHAR_W - 2;

  function automatic logic [AW-1:0] hist_addr(input logic [SW-1:0] slot,
                                               input logic [LW-1:0] off);
    return AW'(slot) * AW'(LINE_LENGTH) + AW'(off);
  endfunction

  // slot of the line at cursor position cur (oldest line is position 0)
  function automatic logic [SW-1:0] sel_slot(input logic [SW-1:0]   wslot,
                                             input logic [CNTW-1:0] cnt,
                                             input logic [CNTW-1:0] cur);
    logic [TW-1:0] t;
    t = TW'(wslot) + TW'(HISTORY_DEPTH) - TW'(cnt) + TW'(cur);
    if (t >= TW'(2 * HISTORY_DEPTH)) begin
      t = t - TW'(2 * HISTORY_DEPTH);
    end else if (t >= TW'(HISTORY_DEPTH)) begin
      t = t - TW'(HISTORY_DEPTH);
    end
    return t[SW-1:0];
  endfunction

  back_state_t        state_r, state_nxt;
  logic [LW-1:0]      staged_len_r, staged_len_nxt;
  logic               match_r, match_nxt;
  logic [SW-1:0]      wslot_r, wslot_nxt;
  logic [CNTW-1:0]    count_r, count_nxt;
  logic [CNTW-1:0]    cursor_r, cursor_nxt;
  logic [CHAR_W-1:0]  cmp_char_r, cmp_char_nxt;
  logic [LW-1:0]      copy_idx_r, copy_idx_nxt;
  logic [SW-1:0]      emit_slot_r, emit_slot_nxt;
  logic [LW-1:0]      emit_idx_r, emit_idx_nxt;
  logic [CHAR_W-1:0]  pend_char_r, pend_char_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  result_kind_t       send_kind_r, send_kind_nxt;
  add_status_t        send_status_r, send_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_kind_t       out_kind_r, out_kind_nxt;
  add_status_t        out_status_r, out_status_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CHAR_W-1:0]  hist_mem [MDEPTH];
  logic [CHAR_W-1:0]  hist_rd_r;
  logic               hist_we;
  logic [AW-1:0]      hist_waddr, hist_raddr;
  logic [CHAR_W-1:0]  hist_wdata;
  logic [CHAR_W-1:0]  stg_mem [LINE_LENGTH];
  logic [CHAR_W-1:0]  stg_rd_r;
  logic               stg_we;

  logic [SW-1:0]      newest;
  logic               out_free;
  logic               ring_empty;
  logic               ring_full;
  logic               stage_full;
  logic               next_clamp;
  logic               emit_end;
  logic [CNTW-1:0]    prev_cur, next_cur;

  assign newest     = (wslot_r == '0) ? SW'(HISTORY_DEPTH - 1) : wslot_r - 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign ring_empty = (count_r == '0);
  assign ring_full  = (count_r == CNTW'(HISTORY_DEPTH));
  assign stage_full = (staged_len_r == LW'(LINE_LENGTH - 1));
  assign next_clamp = (CNTW1'(cursor_r) + 1'b1) >= CNTW1'(count_r);
  assign emit_end   = (hist_rd_r == '0) || (emit_idx_r == LW'(LINE_LENGTH - 1));
  assign prev_cur   = (cursor_r != '0) ? cursor_r - 1'b1 : '0;
  assign next_cur   = cursor_r + 1'b1;
  assign q_ready    = (state_r == B_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_CHAR: begin
              if (!ring_empty && match_r && !stage_full) state_nxt = B_CMP;
            end
            OP_END: begin
              if (staged_len_r == '0)          state_nxt = B_SEND;
              else if (!ring_empty && match_r) state_nxt = B_DUP;
              else                             state_nxt = B_COPY;
            end
            OP_PREV: state_nxt = ring_empty ? B_SEND : B_ERD;
            OP_NEXT: state_nxt = (ring_empty || next_clamp) ? B_SEND : B_ERD;
            default: state_nxt = B_IDLE;
          endcase
        end
      end
      B_CMP:  state_nxt = B_IDLE;
      B_DUP:  state_nxt = (hist_rd_r == '0) ? B_SEND : B_COPY;
      B_COPY: begin
        if (copy_idx_r == staged_len_r) state_nxt = B_TERM;
      end
      B_TERM: state_nxt = B_SEND;
      B_ERD:  state_nxt = B_EMIT;
      B_EMIT: begin
        if (emit_end) begin
          if (out_free) state_nxt = B_IDLE;
        end else if (!pend_valid_r || out_free) begin
          state_nxt = B_ERD;
        end
      end
      B_SEND: begin
        if (out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    staged_len_nxt  = staged_len_r;
    match_nxt       = match_r;
    wslot_nxt       = wslot_r;
    count_nxt       = count_r;
    cursor_nxt      = cursor_r;
    cmp_char_nxt    = cmp_char_r;
    copy_idx_nxt    = copy_idx_r;
    emit_slot_nxt   = emit_slot_r;
    emit_idx_nxt    = emit_idx_r;
    pend_char_nxt   = pend_char_r;
    pend_valid_nxt  = pend_valid_r;
    send_kind_nxt   = send_kind_r;
    send_status_nxt = send_status_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_status_nxt  = out_status_r;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    hist_we         = 1'b0;
    hist_waddr      = hist_addr(wslot_r, copy_idx_r);
    hist_wdata      = stg_rd_r;
    hist_raddr      = hist_addr(newest, staged_len_r);
    stg_we          = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            OP_CHAR: begin
              cmp_char_nxt = q_cmd.ch;
              if (!stage_full) begin
                stg_we         = 1'b1;
                staged_len_nxt = staged_len_r + 1'b1;
              end else if (!ring_empty) begin
                match_nxt = 1'b0;   // overlong never counts as duplicate
              end
            end
            OP_END: begin
              copy_idx_nxt    = '0;
              send_kind_nxt   = RK_STATUS;
              send_status_nxt = ST_EMPTY;
              match_nxt       = (staged_len_r == '0) ? 1'b1 : match_r;
            end
            OP_PREV: begin
              send_kind_nxt   = RK_NONE;
              send_status_nxt = ST_STORED;
              emit_idx_nxt    = '0;
              pend_valid_nxt  = 1'b0;
              if (!ring_empty) begin
                cursor_nxt    = prev_cur;
                emit_slot_nxt = sel_slot(wslot_r, count_r, prev_cur);
              end
            end
            OP_NEXT: begin
              send_kind_nxt   = RK_NONE;
              send_status_nxt = ST_STORED;
              emit_idx_nxt    = '0;
              pend_valid_nxt  = 1'b0;
              if (!ring_empty) begin
                if (next_clamp) begin
                  cursor_nxt = count_r - 1'b1;
                end else begin
                  cursor_nxt    = next_cur;
                  emit_slot_nxt = sel_slot(wslot_r, count_r, next_cur);
                end
              end
            end
            default: cursor_nxt = count_r;
          endcase
        end
      end
      B_CMP: begin
        if (hist_rd_r != cmp_char_r) match_nxt = 1'b0;
      end
      B_DUP: begin
        if (hist_rd_r == '0) begin
          send_kind_nxt   = RK_STATUS;
          send_status_nxt = ST_DUP;
          staged_len_nxt  = '0;
          match_nxt       = 1'b1;
        end
      end
      B_COPY: begin
        // staging read runs one byte ahead of the history write
        if (copy_idx_r != '0) begin
          hist_we    = 1'b1;
          hist_waddr = hist_addr(wslot_r, copy_idx_r - 1'b1);
          hist_wdata = stg_rd_r;
        end
        if (copy_idx_r != staged_len_r) copy_idx_nxt = copy_idx_r + 1'b1;
      end
      B_TERM: begin
        hist_we         = 1'b1;
        hist_waddr      = hist_addr(wslot_r, staged_len_r);
        hist_wdata      = '0;
        wslot_nxt       = (wslot_r == SW'(HISTORY_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
        count_nxt       = ring_full ? count_r : count_r + 1'b1;
        cursor_nxt      = ring_full ? count_r : count_r + 1'b1;
        staged_len_nxt  = '0;
        match_nxt       = 1'b1;
        send_kind_nxt   = RK_STATUS;
        send_status_nxt = ST_STORED;
      end
      B_ERD: begin
        hist_raddr = hist_addr(emit_slot_r, emit_idx_r);
      end
      B_EMIT: begin
        hist_raddr = hist_addr(emit_slot_r, emit_idx_r);
        if (emit_end) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = pend_valid_r ? RK_CHAR : RK_NONE;
            out_status_nxt = ST_STORED;
            out_char_nxt   = pend_valid_r ? pend_char_r : '0;
            out_last_nxt   = 1'b1;
          end
        end else if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_kind_nxt   = RK_CHAR;
            out_status_nxt = ST_STORED;
            out_char_nxt   = pend_char_r;
            out_last_nxt   = 1'b0;
          end
          pend_char_nxt  = hist_rd_r;
          pend_valid_nxt = 1'b1;
          emit_idx_nxt   = emit_idx_r + 1'b1;
        end
      end
      B_SEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = send_kind_r;
          out_status_nxt = send_status_r;
          out_char_nxt   = '0;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      staged_len_r <= '0;
      match_r      <= 1'b1;
      wslot_r      <= '0;
      count_r      <= '0;
      cursor_r     <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      staged_len_r <= staged_len_nxt;
      match_r      <= match_nxt;
      wslot_r      <= wslot_nxt;
      count_r      <= count_nxt;
      cursor_r     <= cursor_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_char_r    <= cmp_char_nxt;
    copy_idx_r    <= copy_idx_nxt;
    emit_slot_r   <= emit_slot_nxt;
    emit_idx_r    <= emit_idx_nxt;
    pend_char_r   <= pend_char_nxt;
    send_kind_r   <= send_kind_nxt;
    send_status_r <= send_status_nxt;
    out_kind_r    <= out_kind_nxt;
    out_status_r  <= out_status_nxt;
    out_char_r    <= out_char_nxt;
    out_last_r    <= out_last_nxt;
  end

  // history store: one write, one registered read
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
    hist_rd_r <= hist_mem[hist_raddr];
  end

  // staging buffer: written at staged_len, read by the copy sweep
  always_ff @(posedge clk) begin
    if (stg_we) stg_mem[staged_len_r] <= q_cmd.ch;
    stg_rd_r <= stg_mem[copy_idx_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {{PADW{1'b0}}, out_char_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- hdl/line_history_ring_core.sv -----
// Command line history ring: top level, front end, queue and back end.
// The back end takes a new request only when idle. An empty command or a browse with no entry
// goes straight to the result; a command character may be compared with the newest line; a
// stored line is copied byte by byte from the staging buffer; a returned line is read and sent
// one character at a time, and every result waits for a free result register.
// Reset: synchronous, active low; clears queue and control, memories untouched.
module line_history_ring_core import lhr_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,  // lines kept, 2..256
  parameter int LINE_LENGTH   = LINE_LENGTH_DEF     // bytes per line incl. end, 2..64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] character
  input  logic [TUSER_W-1:0]     in_tuser,   // [1:0] kind
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [1:0] add_status, [9:2] line_char, rest 0
  output logic [TUSER_W-1:0]     out_tuser,  // [1:0] result_kind
  output logic                   out_tlast   // last result of a request
);

  // Front end classifies each request (character, end of command, previous,
  // next, cursor reset) into a four-entry queue; the back end drains it one
  // request at a time and may stall on the result register while the front
  // end keeps taking requests.
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  lhr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_ready   (q_ready)
  );

  // Back end owns the staging buffer, the history memory, the ring pointers,
  // the browse cursor and the output register.
  lhr_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LINE_LENGTH   (LINE_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_ready    (q_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- hdl/lhr_checker.sv -----
// Port-level checks of the line history ring result stream.
// Depends on lhr_pkg; bound to line_history_ring_core.
module lhr_checker import lhr_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [TUSER_W-1:0]     out_tuser,
  input logic                   out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_STATUS |-> out_tlast && out_tdata[9:2] == 8'd0)
    else $error("add status not final or carries a character");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_NONE |-> out_tlast && out_tdata == '0)
    else $error("no-entry result malformed");

  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == RK_CHAR |-> out_tdata[1:0] == 2'd0 &&
                                           out_tdata[9:2] != 8'd0)
    else $error("line character zero or status set");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind line_history_ring_core lhr_checker u_lhr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

// ----- test/history_ring_checker.sv -----
`timescale 1ns / 100ps
// Checker for the line history ring: watches both streams, predicts every
// result from the accepted requests and compares field by field. Needs lhr_pkg.
module history_ring_checker import lhr_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int LINE_LENGTH   = LINE_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [TUSER_W-1:0]     in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [TUSER_W-1:0]     out_tuser,
  input  logic                   out_tlast,
  output int                     mismatch_count,
  output int                     results_due
);

  typedef struct packed {
    result_kind_t      kind;
    add_status_t       status;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } reply_t;

  logic [CHAR_W-1:0] history_lines [HISTORY_DEPTH][LINE_LENGTH];
  logic [CHAR_W-1:0] staged_text [LINE_LENGTH];
  int unsigned       staged_len;
  bit                still_equal;    // staged text still a prefix of the newest line
  int unsigned       write_slot;
  int unsigned       stored_lines;
  int unsigned       cursor;
  reply_t            due_q[$];

  function automatic int unsigned newest_slot();
    return (write_slot + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
  endfunction

  function automatic int unsigned selected_slot();
    return (write_slot + HISTORY_DEPTH - stored_lines + cursor) % HISTORY_DEPTH;
  endfunction

  // a stored line comes back one character per result, last flag on the end
  function automatic void return_line(int unsigned slot);
    int unsigned i;
    i = 0;
    if (history_lines[slot][0] == '0) begin
      due_q.push_back('{RK_NONE, ST_STORED, '0, 1'b1});
    end
    while (i < LINE_LENGTH - 1 && history_lines[slot][i] != '0) begin
      due_q.push_back('{RK_CHAR, ST_STORED, history_lines[slot][i],
                        (i == LINE_LENGTH - 2) || (history_lines[slot][i+1] == '0)});
      i++;
    end
  endfunction

  function automatic void finish_command();
    add_status_t status;
    if (staged_len == 0) begin
      status = ST_EMPTY;
    end else if (stored_lines > 0 && still_equal &&
                 history_lines[newest_slot()][staged_len] == '0) begin
      status = ST_DUP;
    end else begin
      for (int unsigned i = 0; i < staged_len; i++)
        history_lines[write_slot][i] = staged_text[i];
      history_lines[write_slot][staged_len] = '0;
      write_slot = (write_slot + 1) % HISTORY_DEPTH;
      if (stored_lines < HISTORY_DEPTH) stored_lines++;
      cursor = stored_lines;
      status = ST_STORED;
    end
    staged_len  = 0;
    still_equal = 1'b1;
    due_q.push_back('{RK_STATUS, status, '0, 1'b1});
  endfunction

  // overlong tails are dropped from the copy but still break the match
  function automatic void take_character(logic [CHAR_W-1:0] c);
    if (stored_lines > 0 && still_equal) begin
      if (staged_len >= LINE_LENGTH - 1 || history_lines[newest_slot()][staged_len] != c)
        still_equal = 1'b0;
    end
    if (staged_len < LINE_LENGTH - 1) begin
      staged_text[staged_len] = c;
      staged_len++;
    end
  endfunction

  function automatic void apply_request(in_kind_t kind, logic [CHAR_W-1:0] c);
    case (kind)
      KIND_CHAR: begin
        if (c == '0) finish_command();
        else take_character(c);
      end
      KIND_CURSOR: begin
        cursor = stored_lines;
      end
      default: begin
        if (stored_lines == 0) begin
          due_q.push_back('{RK_NONE, ST_STORED, '0, 1'b1});
        end else if (kind == KIND_PREV) begin
          if (cursor > 0) cursor--;
          return_line(selected_slot());
        end else if (cursor + 1 >= stored_lines) begin
          cursor = stored_lines - 1;
          due_q.push_back('{RK_NONE, ST_STORED, '0, 1'b1});
        end else begin
          cursor++;
          return_line(selected_slot());
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int s = 0; s < HISTORY_DEPTH; s++)
        for (int i = 0; i < LINE_LENGTH; i++)
          history_lines[s][i] = '0;
      staged_len     = 0;
      still_equal    = 1'b1;
      write_slot     = 0;
      stored_lines   = 0;
      cursor         = 0;
      due_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $error("result with nothing expected: tuser %0d tdata 0x%0h tlast %0b",
                 out_tuser, out_tdata, out_tlast);
          mismatch_count++;
        end else begin
          want = due_q.pop_front();
          if (out_tuser !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[1:0] !== want.status) begin
            $error("add_status: expected %0d, got %0d", want.status, out_tdata[1:0]);
            mismatch_count++;
          end
          if (out_tdata[9:2] !== want.ch) begin
            $error("line_char: expected 0x%02h, got 0x%02h", want.ch, out_tdata[9:2]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            mismatch_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:10] !== '0) begin
            $error("tdata padding: expected 0, got 0x%0h", out_tdata[OUT_TDATA_W-1:10]);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_request(in_kind_t'(in_tuser), in_tdata[CHAR_W-1:0]);
    end
    results_due <= due_q.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the line history ring testbench: clock, reset, request stimulus,
// result stall pattern, watchdog and verdict. Needs lhr_pkg and the checker.
module tb_top;
  import lhr_pkg::*;

  localparam int RANDOM_ITEMS   = 500;
  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int TAIL_CYCLES    = 200;   // covers a full-length copy sweep

  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_CHOPPY,  // ready with a chance of two in three
    RX_SLOW     // ready with a chance of one in six
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [TUSER_W-1:0]     in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0]     out_tuser;
  logic                   out_tlast;
  int                     mismatch_count;
  int                     results_due;

  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  int          sent = 0;           // requests accepted so far
  bit          drained = 1'b0;     // mid-run drain already done
  logic [7:0]  draft[$];           // command being built
  logic [7:0]  recent[$];          // last nonempty command sent

  always #6 clk = ~clk;

  line_history_ring_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  history_ring_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // Result side: the stall mode changes after a random stretch, so the
  // back end sees open stretches, choppy ready and long back-pressure.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= ($urandom_range(0, 2) != 0);
      default:   out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("line_history_ring_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request. Bursts of random length, separated by random gaps; a gap
  // of zero keeps valid high straight into the next burst.
  task automatic send_request(input in_kind_t kind, input logic [7:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // Sends the draft as a command, optionally with browse requests mixed in
  // (the staged text must survive them).
  task automatic send_command(input bit with_browse);
    foreach (draft[i]) begin
      if (with_browse && $urandom_range(0, 3) == 0)
        send_request(in_kind_t'(2'($urandom_range(1, 3))), 8'($urandom_range(0, 255)));
      send_request(KIND_CHAR, draft[i]);
    end
    send_request(KIND_CHAR, 8'h00);
    if (draft.size() > 0) recent = draft;
  endtask

  // narrow picks from three letters so near-duplicates show up often
  task automatic make_line(input int len, input bit narrow);
    draft.delete();
    repeat (len)
      draft.push_back(narrow ? 8'($urandom_range(97, 99)) : 8'($urandom_range(1, 255)));
  endtask

  initial begin
    int pick;
    int len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ring, empty command, store, duplicate, prefix of the
    // newest line, clamping at both ends, browsing inside a command.
    send_request(KIND_PREV,   8'hA5);  // empty ring: no entry
    send_request(KIND_NEXT,   8'h5A);  // empty ring: no entry
    send_request(KIND_CURSOR, 8'hFF);
    send_request(KIND_CHAR,   8'h00);  // empty command
    send_request(KIND_CHAR,   8'hFF);
    send_request(KIND_CHAR,   8'h01);
    send_request(KIND_CHAR,   8'h00);  // stored
    send_request(KIND_CHAR,   8'hFF);
    send_request(KIND_CHAR,   8'h01);
    send_request(KIND_CHAR,   8'h00);  // duplicate of newest
    send_request(KIND_CHAR,   8'hFF);
    send_request(KIND_CHAR,   8'h00);  // prefix only: stored
    send_request(KIND_PREV,   8'h00);
    send_request(KIND_PREV,   8'h00);  // oldest line
    send_request(KIND_PREV,   8'h00);  // clamped at oldest, same line again
    send_request(KIND_NEXT,   8'h00);
    send_request(KIND_NEXT,   8'h00);  // past newest: no entry
    send_request(KIND_CURSOR, 8'h00);
    send_request(KIND_CHAR,   8'h80);
    send_request(KIND_NEXT,   8'h00);  // browse while a command is staged
    send_request(KIND_CHAR,   8'h7F);
    send_request(KIND_CHAR,   8'h00);
    send_request(KIND_NEXT,   8'h00);
    send_request(KIND_PREV,   8'h00);

    // Random: mostly well-formed commands, many of them equal or close to
    // the newest line, plus browsing, cursor resets and raw noise.
    while (sent < 24 + RANDOM_ITEMS) begin
      if (!drained && sent >= 24 + RANDOM_ITEMS / 2) begin
        // hold off until the ring has answered everything
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 33) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(60, 70);
          1, 2, 3: len = $urandom_range(7, 30);
          default: len = $urandom_range(1, 6);
        endcase
        make_line(len, $urandom_range(0, 1));
        send_command($urandom_range(0, 7) == 0);
      end else if (pick < 48) begin
        draft = recent;
        send_command($urandom_range(0, 4) == 0);
      end else if (pick < 57) begin
        draft = recent;
        case ($urandom_range(0, 2))
          0: if (draft.size() > 1) void'(draft.pop_back());
          1: draft.push_back(8'($urandom_range(97, 99)));
          default: if (draft.size() > 0)
            draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(97, 99));
        endcase
        send_command(1'b0);
      end else if (pick < 59) begin
        // full-length line, its duplicate, then overlong copies that share
        // the stored prefix but must never count as duplicates
        make_line(LINE_LENGTH_DEF - 1, 1'b0);
        send_command(1'b0);
        send_command(1'b0);
        repeat ($urandom_range(1, 3)) draft.push_back(8'($urandom_range(1, 255)));
        send_command(1'b0);
        send_command(1'b0);
      end else if (pick < 64) begin
        draft.delete();
        send_command(1'b0);
      end else if (pick < 84) begin
        repeat ($urandom_range(1, 6))
          send_request($urandom_range(0, 1) ? KIND_PREV : KIND_NEXT,
                       8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_request(KIND_CURSOR, 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        make_line($urandom_range(1, 8), 1'b1);
        send_command(1'b1);
      end else begin
        repeat ($urandom_range(1, 5))
          send_request(in_kind_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("line_history_ring_core test passed");
    end else begin
      $display("line_history_ring_core test failed");
    end
    $finish;
  end

endmodule

// ----- line_history_ring_core.f -----
hdl/lhr_pkg.sv
hdl/lhr_front.sv
hdl/lhr_back.sv
hdl/line_history_ring_core.sv
hdl/lhr_checker.sv
test/history_ring_checker.sv
test/tb_top.sv
